@@ src/bfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Banked register file package
// Shared types, storage map and reset contents for the banked register file.
// ----------------------------------------------------------------------------
`default_nettype none

package bfr_pkg;

  localparam int unsigned DataW = 32;

  // Storage map: base r0..r15, FIQ r8..r14, then r13/r14 pairs for IRQ,
  // supervisor, abort and undefined, then six saved status words.
  localparam int unsigned FiqBase    = 16;
  localparam int unsigned IrqBase    = 23;
  localparam int unsigned SvcBase    = 25;
  localparam int unsigned AbtBase    = 27;
  localparam int unsigned UndBase    = 29;
  localparam int unsigned StatusBase = 31;
  localparam int unsigned MemDepth   = 37;
  localparam int unsigned AddrW      = $clog2(MemDepth);

  localparam logic [3:0]       PcIndex = 4'd15;
  localparam logic [DataW-1:0] PcMask  = 32'hFFFF_FFFE;

  localparam logic [DataW-1:0] RstR0     = 32'h0000_0CA5;
  localparam logic [DataW-1:0] RstSp     = 32'h0300_7F00;
  localparam logic [DataW-1:0] RstLr     = 32'h0800_0000;
  localparam logic [DataW-1:0] RstIrqSp  = 32'h0300_7FA0;
  localparam logic [DataW-1:0] RstSvcSp  = 32'h0300_7FE0;
  localparam logic [DataW-1:0] RstFiqSts = 32'hF000_00FF;

  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [1:0] {
    ACT_RD_REG = 2'd0,
    ACT_WR_REG = 2'd1,
    ACT_RD_STS = 2'd2,
    ACT_WR_STS = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MODE_USR = 3'd0,
    MODE_FIQ = 3'd1,
    MODE_IRQ = 3'd2,
    MODE_SVC = 3'd3,
    MODE_ABT = 3'd4,
    MODE_UND = 3'd5,
    MODE_SYS = 3'd6,
    MODE_BAD = 3'd7
  } mode_t;

  // One decoded request on its way through the file.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             fault;
    addr_t            addr;
    logic [DataW-1:0] wdata;
  } cmd_t;

  function automatic logic [DataW-1:0] reset_value(addr_t addr);
    logic [DataW-1:0] v;
    v = '0;
    if (addr == addr_t'(0)) begin
      v = RstR0;
    end else if (addr == addr_t'(13)) begin
      v = RstSp;
    end else if (addr == addr_t'(14)) begin
      v = RstLr;
    end else if (addr == addr_t'(IrqBase)) begin
      v = RstIrqSp;
    end else if (addr == addr_t'(SvcBase)) begin
      v = RstSvcSp;
    end else if (addr == addr_t'(StatusBase)) begin
      v = RstFiqSts;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/bfr_decode.sv @@
// ----------------------------------------------------------------------------
// Banked register file request decoder
// Maps action, mode, register and override onto one storage entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_decode
  import bfr_pkg::*;
(
  input  wire logic [1:0]       action,
  input  wire logic [2:0]       mode,
  input  wire logic [3:0]       reg_index,
  input  wire logic             user_bank,
  input  wire logic [DataW-1:0] write_value,
  output cmd_t                  cmd
);

  logic  bank_ok;
  addr_t bank_addr;
  logic  sts_ok;
  addr_t sts_addr;
  addr_t base_addr;
  addr_t pair_ofs;

  assign base_addr = addr_t'(reg_index);
  // Registers 13 and 14 map to the first and second entry of a pair.
  assign pair_ofs  = reg_index[0] ? addr_t'(0) : addr_t'(1);

  always_comb begin
    bank_ok   = 1'b1;
    bank_addr = base_addr;
    unique case (mode_t'(mode))
      MODE_USR, MODE_SYS: bank_addr = base_addr;
      MODE_FIQ: begin
        if (reg_index[3]) begin
          bank_addr = addr_t'(FiqBase) + addr_t'(reg_index[2:0]);
        end
      end
      MODE_IRQ: if (reg_index >= 4'd13) bank_addr = addr_t'(IrqBase) + pair_ofs;
      MODE_SVC: if (reg_index >= 4'd13) bank_addr = addr_t'(SvcBase) + pair_ofs;
      MODE_ABT: if (reg_index >= 4'd13) bank_addr = addr_t'(AbtBase) + pair_ofs;
      MODE_UND: if (reg_index >= 4'd13) bank_addr = addr_t'(UndBase) + pair_ofs;
      default:  bank_ok = 1'b0;
    endcase
  end

  always_comb begin
    sts_ok   = 1'b1;
    sts_addr = addr_t'(StatusBase);
    unique case (mode_t'(mode))
      MODE_FIQ:           sts_addr = addr_t'(StatusBase);
      MODE_SVC:           sts_addr = addr_t'(StatusBase + 1);
      MODE_ABT:           sts_addr = addr_t'(StatusBase + 2);
      MODE_IRQ:           sts_addr = addr_t'(StatusBase + 3);
      MODE_UND:           sts_addr = addr_t'(StatusBase + 4);
      MODE_USR, MODE_SYS: sts_addr = addr_t'(StatusBase + 5);
      default:            sts_ok   = 1'b0;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.wdata = write_value;
    unique case (action_t'(action))
      ACT_RD_REG: begin
        if (reg_index == PcIndex || user_bank) begin
          cmd.rd   = 1'b1;
          cmd.addr = base_addr;
        end else begin
          cmd.rd    = bank_ok;
          cmd.fault = !bank_ok;
          cmd.addr  = bank_addr;
        end
      end
      ACT_WR_REG: begin
        if (user_bank) begin
          cmd.wr   = 1'b1;
          cmd.addr = base_addr;
        end else if (reg_index == PcIndex) begin
          cmd.wr    = 1'b1;
          cmd.addr  = base_addr;
          cmd.wdata = write_value & PcMask;
        end else begin
          cmd.wr    = bank_ok;
          cmd.fault = !bank_ok;
          cmd.addr  = bank_addr;
        end
      end
      ACT_RD_STS: begin
        cmd.rd    = sts_ok;
        cmd.fault = !sts_ok;
        cmd.addr  = sts_addr;
      end
      ACT_WR_STS: begin
        cmd.wr    = sts_ok;
        cmd.fault = !sts_ok;
        cmd.addr  = sts_addr;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/bfr_store.sv @@
// ----------------------------------------------------------------------------
// Banked register file storage
// One synchronous memory for all register copies and saved status words,
// with per-entry valid bits standing in for the reset contents.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_store
  import bfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire addr_t            rd_addr,
  input  wire logic             wr_en,
  input  wire addr_t            wr_addr,
  input  wire logic [DataW-1:0] wr_data,
  output logic      [DataW-1:0] rd_data
);

  logic [DataW-1:0] mem [MemDepth];
  logic [MemDepth-1:0] vld_r;
  logic [DataW-1:0] mem_q_r;
  logic [DataW-1:0] rst_val_r;
  logic [DataW-1:0] fwd_data_r;
  logic             hit_r;
  logic             fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // A write retiring on the same edge as a read of that entry is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_r      <= vld_r[rd_addr];
      rst_val_r  <= reset_value(rd_addr);
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (hit_r ? mem_q_r : rst_val_r);

endmodule

`default_nettype wire

@@ src/banked_register_file_unit.sv @@
// ----------------------------------------------------------------------------
// Banked register file unit
// Mode-banked processor register file with saved status words.
// ----------------------------------------------------------------------------
// Each request reads or writes one register or saved status word as seen from
// the given mode. The unit sustains one request per clock while out_ready allows
// it: a request reads the storage memory on the edge it is accepted, and its
// result is loaded into the output register as it leaves the stage register,
// on the same edge that its write, if any, retires. A write immediately
// followed by a read of the same entry is forwarded. Faulting requests
// return zero and change nothing.
`default_nettype none

module banked_register_file_unit
  import bfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_action,
  input  wire logic [2:0]       in_mode,
  input  wire logic [3:0]       in_reg_index,
  input  wire logic             in_user_bank,
  input  wire logic [DataW-1:0] in_write_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [DataW-1:0] out_read_value,
  output logic                  out_fault
);

  cmd_t             dec_cmd;
  cmd_t             s1_cmd_r;
  logic             s1_valid_r;
  logic             advance;
  logic             accept;
  logic [DataW-1:0] rd_data;
  logic             out_valid_r;
  logic [DataW-1:0] out_read_value_r;
  logic             out_fault_r;

  bfr_decode u_decode (
    .action      (in_action),
    .mode        (in_mode),
    .reg_index   (in_reg_index),
    .user_bank   (in_user_bank),
    .write_value (in_write_value),
    .cmd         (dec_cmd)
  );

  bfr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && dec_cmd.rd),
    .rd_addr (dec_cmd.addr),
    .wr_en   (advance && s1_cmd_r.wr),
    .wr_addr (s1_cmd_r.addr),
    .wr_data (s1_cmd_r.wdata),
    .rd_data (rd_data)
  );

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_value_r <= s1_cmd_r.rd ? rd_data : '0;
      out_fault_r      <= s1_cmd_r.fault;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_fault      = out_fault_r;

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_read_value == '0)
    else $error("faulting result carries a non-zero value");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_cmd_r.rd && s1_cmd_r.wr))
    else $error("request both reads and writes");

  a_fault_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_cmd_r.fault |-> !s1_cmd_r.rd && !s1_cmd_r.wr)
    else $error("faulting request touches storage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_cmd_r))
    else $error("stalled request lost or altered");

  a_retire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("retired request produced no result");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Banked register file unit testbench
// Drives register and saved status requests through the valid/ready input,
// predicts each result from a private copy of every bank, and compares the
// returned read value and fault flag in order. Both sides idle at random, the
// receiver holds off once for a long stretch, and the sender drains once.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import bfr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomCount = 500;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldStart   = 150;
  localparam int unsigned HoldCycles  = 300;

  // Layout of the predictor's r13/r14 pairs and saved status words.
  localparam int unsigned PairIrq = 0;
  localparam int unsigned PairSvc = 2;
  localparam int unsigned PairAbt = 4;
  localparam int unsigned PairUnd = 6;
  localparam int StsFiq = 0;
  localparam int StsSvc = 1;
  localparam int StsAbt = 2;
  localparam int StsIrq = 3;
  localparam int StsUnd = 4;
  localparam int StsUsr = 5;
  localparam int NoSlot = -1;

  typedef enum logic [1:0] {
    CELL_BASE,
    CELL_FIQ,
    CELL_PAIR,
    CELL_NONE
  } cell_kind_t;

  typedef struct {
    action_t          act;
    mode_t            mode;
    logic [3:0]       idx;
    logic             ovr;
    logic [DataW-1:0] wdata;
    int unsigned      gap;
    bit               drain;
  } access_t;

  typedef struct {
    logic [DataW-1:0] value;
    logic             fault;
  } result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_action = '0;
  logic [2:0]       in_mode = '0;
  logic [3:0]       in_reg_index = '0;
  logic             in_user_bank = 1'b0;
  logic [DataW-1:0] in_write_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DataW-1:0] out_read_value;
  logic             out_fault;

  logic [DataW-1:0] gpr_base [16];
  logic [DataW-1:0] gpr_fiq [7];
  logic [DataW-1:0] gpr_pair [8];
  logic [DataW-1:0] saved_sts [6];

  access_t     pending_accesses[$];
  result_t     expected_results[$];
  access_t     cur;
  int unsigned accepted = 0;
  int unsigned checked = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_count = 0;
  bit          hold_done = 1'b0;
  logic        hold_off = 1'b0;

  banked_register_file_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_mode        (in_mode),
    .in_reg_index   (in_reg_index),
    .in_user_bank   (in_user_bank),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_fault      (out_fault)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic access_t make_access(action_t act, mode_t mode, logic [3:0] idx,
                                          logic ovr, logic [DataW-1:0] wdata);
    access_t a;
    a.act = act;
    a.mode = mode;
    a.idx = idx;
    a.ovr = ovr;
    a.wdata = wdata;
    a.gap = 0;
    a.drain = 1'b0;
    return a;
  endfunction

  // Finds the storage behind register n (0..14) as seen from the mode.
  function automatic cell_kind_t locate_cell(mode_t mode, logic [3:0] n,
                                             output int unsigned slot);
    cell_kind_t kind;
    kind = CELL_BASE;
    slot = n;
    unique case (mode)
      MODE_USR, MODE_SYS: kind = CELL_BASE;
      MODE_FIQ: begin
        if (n >= 8) begin
          kind = CELL_FIQ;
          slot = n - 8;
        end
      end
      MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND: begin
        if (n >= 13) begin
          kind = CELL_PAIR;
          unique case (mode)
            MODE_IRQ: slot = PairIrq + n - 13;
            MODE_SVC: slot = PairSvc + n - 13;
            MODE_ABT: slot = PairAbt + n - 13;
            default:  slot = PairUnd + n - 13;
          endcase
        end
      end
      default: kind = CELL_NONE;
    endcase
    return kind;
  endfunction

  function automatic int status_slot(mode_t mode);
    unique case (mode)
      MODE_FIQ:           return StsFiq;
      MODE_SVC:           return StsSvc;
      MODE_ABT:           return StsAbt;
      MODE_IRQ:           return StsIrq;
      MODE_UND:           return StsUnd;
      MODE_USR, MODE_SYS: return StsUsr;
      default:            return NoSlot;
    endcase
  endfunction

  // Applies one request to the predicted banks and returns what it yields.
  function automatic result_t apply_access(access_t a);
    result_t     r;
    cell_kind_t  kind;
    int unsigned slot;
    int          sts;
    r.value = '0;
    r.fault = 1'b0;
    unique case (a.act)
      ACT_RD_REG: begin
        if (a.idx == PcIndex || a.ovr) begin
          r.value = gpr_base[a.idx];
        end else begin
          kind = locate_cell(a.mode, a.idx, slot);
          unique case (kind)
            CELL_BASE: r.value = gpr_base[slot];
            CELL_FIQ:  r.value = gpr_fiq[slot];
            CELL_PAIR: r.value = gpr_pair[slot];
            default:   r.fault = 1'b1;
          endcase
        end
      end
      ACT_WR_REG: begin
        if (a.ovr) begin
          gpr_base[a.idx] = a.wdata;
        end else if (a.idx == PcIndex) begin
          gpr_base[PcIndex] = a.wdata & PcMask;
        end else begin
          kind = locate_cell(a.mode, a.idx, slot);
          unique case (kind)
            CELL_BASE: gpr_base[slot] = a.wdata;
            CELL_FIQ:  gpr_fiq[slot] = a.wdata;
            CELL_PAIR: gpr_pair[slot] = a.wdata;
            default:   r.fault = 1'b1;
          endcase
        end
      end
      default: begin
        sts = status_slot(a.mode);
        if (sts == NoSlot) begin
          r.fault = 1'b1;
        end else if (a.act == ACT_RD_STS) begin
          r.value = saved_sts[sts];
        end else begin
          saved_sts[sts] = a.wdata;
        end
      end
    endcase
    return r;
  endfunction

  // Sender: offers queued requests, idling between them as each one asks.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_access(cur));
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_accesses.size() != 0 &&
                     (!pending_accesses[0].drain || (!in_valid && accepted == checked))) begin
          cur = pending_accesses.pop_front();
          in_valid <= 1'b1;
          in_action <= cur.act;
          in_mode <= cur.mode;
          in_reg_index <= cur.idx;
          in_user_bank <= cur.ovr;
          in_write_value <= cur.wdata;
          tx_wait = cur.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %08h fault %0b",
                                    out_read_value, out_fault));
        end else begin
          want = expected_results.pop_front();
          if (out_read_value !== want.value) begin
            report_mismatch($sformatf("result %0d read value %08h, expected %08h",
                                      checked, out_read_value, want.value));
          end
          if (out_fault !== want.fault) begin
            report_mismatch($sformatf("result %0d fault %0b, expected %0b",
                                      checked, out_fault, want.fault));
          end
        end
        checked <= checked + 1;
        rx_wait = ((checked / 64) % 3 == 0) ? 0 : $urandom_range(0, 15);
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One long hold-off on the result side, so that the unit backs up.
  always @(posedge clk) begin
    if (rst_n && !hold_done && accepted >= HoldStart) begin
      if (hold_count < HoldCycles) begin
        hold_off <= 1'b1;
        hold_count++;
      end else begin
        hold_off <= 1'b0;
        hold_done = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    access_t a;
    foreach (gpr_base[i]) gpr_base[i] = '0;
    foreach (gpr_fiq[i]) gpr_fiq[i] = '0;
    foreach (gpr_pair[i]) gpr_pair[i] = '0;
    foreach (saved_sts[i]) saved_sts[i] = '0;
    gpr_base[0] = RstR0;
    gpr_base[13] = RstSp;
    gpr_base[14] = RstLr;
    gpr_pair[PairIrq] = RstIrqSp;
    gpr_pair[PairSvc] = RstSvcSp;
    saved_sts[StsFiq] = RstFiqSts;

    // Reset contents, program counter handling, banking, the override and
    // the invalid mode, mostly back to back so that forwarding is exercised.
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_USR, 4'd0, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_USR, 4'd13, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_IRQ, 4'd13, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_SVC, 4'd13, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_SYS, 4'd14, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_STS, MODE_FIQ, 4'd0, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_WR_REG, MODE_USR, 4'd15, 1'b0, '1));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_BAD, 4'd15, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_WR_REG, MODE_BAD, 4'd15, 1'b1, '1));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_FIQ, 4'd15, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_WR_REG, MODE_FIQ, 4'd8, 1'b0, '1));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_USR, 4'd8, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_FIQ, 4'd8, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_SVC, 4'd13, 1'b1, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_BAD, 4'd3, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_WR_REG, MODE_BAD, 4'd3, 1'b0, '1));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_BAD, 4'd3, 1'b1, '0));
    pending_accesses.push_back(make_access(ACT_RD_STS, MODE_BAD, 4'd0, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_WR_STS, MODE_BAD, 4'd0, 1'b0, '1));
    pending_accesses.push_back(make_access(ACT_WR_STS, MODE_SYS, 4'd0, 1'b0, '1));
    pending_accesses.push_back(make_access(ACT_RD_STS, MODE_USR, 4'd0, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_WR_REG, MODE_UND, 4'd14, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_REG, MODE_UND, 4'd14, 1'b0, '0));
    pending_accesses.push_back(make_access(ACT_RD_STS, MODE_ABT, 4'd15, 1'b1, '0));

    for (int i = 0; i < RandomCount; i++) begin
      a.act = action_t'($urandom_range(0, 3));
      a.mode = ($urandom_range(0, 9) == 0) ? MODE_BAD : mode_t'($urandom_range(0, 6));
      // Half the requests aim at the banked upper registers.
      a.idx = $urandom_range(0, 1) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 15));
      a.ovr = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       a.wdata = '0;
        1:       a.wdata = '1;
        default: a.wdata = $urandom;
      endcase
      a.gap = ((i / 100) % 2 == 0) ? 0 : $urandom_range(0, 15);
      a.drain = (i == 300);
      pending_accesses.push_back(a);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_accesses.size() != 0 || in_valid || accepted != checked) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
